/* design/efsd_pkg.sv */
// Shared types and constants of the earliest-free server dispatcher.
package efsd_pkg;

   localparam int SERVERS_DEFAULT = 16;

   localparam int TIME_W    = 17;
   localparam int MINS_W    = 16;
   localparam int CAP_W     = 10;
   localparam int SVC_W     = 16;
   localparam int NSRV_W    = 5;
   localparam int IDX_OUT_W = 4;
   localparam int FREE_W    = 32;
   localparam int WAIT_W    = 32;
   localparam int TOTAL_W   = 48;
   localparam int COUNT_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 17;

   localparam int QUEUE_DEPTH  = 4;
   localparam int SECS_PER_MIN = 60;

   localparam logic [NSRV_W-1:0] SERVERS_RESET = NSRV_W'(16);
   localparam logic [TIME_W-1:0] OPEN_RESET    = TIME_W'(28800);
   localparam logic [TIME_W-1:0] CLOSE_RESET   = TIME_W'(61200);
   localparam logic [CAP_W-1:0]  MAX_SVC_RESET = CAP_W'(60);

   typedef enum logic [1:0] {
      OP_JOB,
      OP_DROP,
      OP_CLEAR
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SERVERS,
      CSR_OPEN,
      CSR_CLOSE,
      CSR_MAX_SVC
   } csr_type;

   typedef struct packed {
      op_type              op;
      logic [TIME_W-1:0]   arrival;
      logic [SVC_W-1:0]    svc;
   } item_type;

endpackage

/* design/earliest_free_server_dispatcher.sv */
// Earliest-free server dispatcher: top level with configuration registers.
//
// Each request word is a job (arrival second, service minutes) or a clear.
// Jobs arriving after close_time are dropped; others get their service capped
// at max_service_minutes and go to the active server that frees up first,
// lowest index on ties. Every word yields exactly one response word with the
// job's wait, the saturating total wait and the served count. A clear resets
// all free times to the current open_time and zeroes the totals; open_time
// written later takes effect only at the next clear. A front stage classifies
// words and feeds a queue of four; the dispatch engine scans one server free
// time per cycle from a store with one read and one write port; a dispatched
// job then passes calc, update and done; a dropped job or a clear goes to done.
// The front keeps taking words while the engine works, until the queue fills.
// The user writes configuration only while idle; the block does not enforce it.
module earliest_free_server_dispatcher #(
   parameter int SERVERS = efsd_pkg::SERVERS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [efsd_pkg::TIME_W-1:0]       req_arrival_time,
   input  logic [efsd_pkg::MINS_W-1:0]       req_service_minutes,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_accepted,
   output logic [efsd_pkg::IDX_OUT_W-1:0]    rsp_server_index,
   output logic [efsd_pkg::WAIT_W-1:0]       rsp_wait_seconds,
   output logic [efsd_pkg::TOTAL_W-1:0]      rsp_total_wait_seconds,
   output logic [efsd_pkg::COUNT_W-1:0]      rsp_served_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [efsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [efsd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import efsd_pkg::*;

   logic [NSRV_W-1:0]  servers_ff;
   logic [TIME_W-1:0]  open_ff;
   logic [TIME_W-1:0]  close_ff;
   logic [CAP_W-1:0]   max_svc_ff;

   logic               front_valid;
   logic               front_ready;
   item_type           front_item;
   logic               q_valid;
   logic               q_pop;
   item_type           q_item;

   // registers are always writable
   assign csr_ready = 1'b1;

   // decode the register index, keep only each register's width
   always_ff @(posedge clock) begin
      if (reset) begin
         servers_ff <= SERVERS_RESET;
         open_ff    <= OPEN_RESET;
         close_ff   <= CLOSE_RESET;
         max_svc_ff <= MAX_SVC_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_type'(csr_index))
            CSR_SERVERS: servers_ff <= csr_data[NSRV_W-1:0];
            CSR_OPEN:    open_ff    <= csr_data[TIME_W-1:0];
            CSR_CLOSE:   close_ff   <= csr_data[TIME_W-1:0];
            CSR_MAX_SVC: max_svc_ff <= csr_data[CAP_W-1:0];
         endcase
      end
   end

   // classify and cap
   efsd_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_arrival_time    (req_arrival_time),
      .req_service_minutes (req_service_minutes),
      .close_time          (close_ff),
      .max_service_minutes (max_svc_ff),
      .item_valid          (front_valid),
      .item                (front_item),
      .item_ready          (front_ready)
   );

   // decouple front from engine
   efsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_item)
   );

   // scan, dispatch, report
   efsd_back #(
      .SERVERS (SERVERS)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_valid                (q_valid),
      .q_pop                  (q_pop),
      .q_item                 (q_item),
      .servers_in_use         (servers_ff),
      .open_time              (open_ff),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_accepted           (rsp_accepted),
      .rsp_server_index       (rsp_server_index),
      .rsp_wait_seconds       (rsp_wait_seconds),
      .rsp_total_wait_seconds (rsp_total_wait_seconds),
      .rsp_served_count       (rsp_served_count)
   );

   // a dropped job or a clear never reports a wait
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_wait_seconds == '0 && rsp_server_index == '0)
      else $error("nonzero wait or index on a word that was not dispatched");

   // a dispatched job is counted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_served_count != '0)
      else $error("dispatched job left the served count at zero");

   // the running total already includes this job's wait
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_total_wait_seconds >= TOTAL_W'(rsp_wait_seconds))
      else $error("total wait below this job's wait");

endmodule

/* design/efsd_front.sv */
// Front stage: takes request words, classifies them and caps the service length.
module efsd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [efsd_pkg::TIME_W-1:0]   req_arrival_time,
   input  logic [efsd_pkg::MINS_W-1:0]   req_service_minutes,
   input  logic [efsd_pkg::TIME_W-1:0]   close_time,
   input  logic [efsd_pkg::CAP_W-1:0]    max_service_minutes,
   output logic                          item_valid,
   output efsd_pkg::item_type            item,
   input  logic                          item_ready
);
   import efsd_pkg::*;

   logic              valid_ff;
   item_type          item_ff;
   item_type          item_in;
   logic [CAP_W-1:0]  capped;
   logic              load;

   // cap in minutes, then convert to seconds
   always_comb begin
      if (req_service_minutes > MINS_W'(max_service_minutes)) begin
         capped = max_service_minutes;
      end else begin
         capped = req_service_minutes[CAP_W-1:0];
      end
      item_in.arrival = req_arrival_time;
      item_in.svc     = SVC_W'(capped) * SVC_W'(SECS_PER_MIN);
      if (req_kind) begin
         item_in.op = OP_CLEAR;
      end else if (req_arrival_time > close_time) begin
         item_in.op = OP_DROP;
      end else begin
         item_in.op = OP_JOB;
      end
   end

   assign load      = !valid_ff || item_ready;
   assign req_stall = !load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= req_valid;
         if (req_valid) begin
            item_ff <= item_in;
         end
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* design/efsd_queue.sv */
// Short queue between the classifying front and the dispatch engine.
module efsd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  efsd_pkg::item_type  push_item,
   output logic                pop_valid,
   input  logic                pop,
   output efsd_pkg::item_type  pop_item
);
   import efsd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                do_push;
   logic                do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            slot_ff[wr_ptr_ff] <= push_item;
            if (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) begin
               wr_ptr_ff <= '0;
            end else begin
               wr_ptr_ff <= wr_ptr_ff + 1'b1;
            end
         end
         if (do_pop) begin
            if (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) begin
               rd_ptr_ff <= '0;
            end else begin
               rd_ptr_ff <= rd_ptr_ff + 1'b1;
            end
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* design/efsd_back.sv */
// Dispatch engine: scans server free times, updates the chosen server and the totals.
module efsd_back #(
   parameter int SERVERS = efsd_pkg::SERVERS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   output logic                           q_pop,
   input  efsd_pkg::item_type             q_item,
   input  logic [efsd_pkg::NSRV_W-1:0]    servers_in_use,
   input  logic [efsd_pkg::TIME_W-1:0]    open_time,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_accepted,
   output logic [efsd_pkg::IDX_OUT_W-1:0] rsp_server_index,
   output logic [efsd_pkg::WAIT_W-1:0]    rsp_wait_seconds,
   output logic [efsd_pkg::TOTAL_W-1:0]   rsp_total_wait_seconds,
   output logic [efsd_pkg::COUNT_W-1:0]   rsp_served_count
);
   import efsd_pkg::*;

   localparam int IW = (SERVERS > 1) ? $clog2(SERVERS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CALC,
      S_UPD,
      S_DONE
   } state_type;

   state_type            state_ff;
   item_type             cur_ff;
   logic [IW-1:0]        last_ff;
   logic [IW-1:0]        rd_idx_ff;
   logic                 issue_ff;
   logic                 pend_ff;
   logic [IW-1:0]        pend_idx_ff;
   logic                 pend_last_ff;
   logic [IW-1:0]        best_ff;
   logic [FREE_W-1:0]    best_val_ff;
   logic [WAIT_W-1:0]    wait_ff;
   logic [FREE_W-1:0]    start_ff;
   logic [SERVERS-1:0]   valid_ff;
   logic                 rd_valid_ff;
   logic [FREE_W-1:0]    rd_data_ff;
   logic [TIME_W-1:0]    clear_open_ff;
   logic [TOTAL_W-1:0]   total_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 res_acc_ff;
   logic [IW-1:0]        res_idx_ff;
   logic [WAIT_W-1:0]    res_wait_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_accepted_ff;
   logic [IDX_OUT_W-1:0] rsp_index_ff;
   logic [WAIT_W-1:0]    rsp_wait_ff;
   logic [TOTAL_W-1:0]   rsp_total_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic [FREE_W-1:0]    free_mem [SERVERS];

   logic [IW-1:0]        last_in;
   logic [FREE_W-1:0]    cur_val;
   logic [FREE_W-1:0]    arr_ext;
   logic [FREE_W:0]      fin_wide;
   logic [FREE_W-1:0]    fin_sat;
   logic [TOTAL_W:0]     total_wide;
   logic                 mem_wr;

   // clamp the active server count to 1..SERVERS, as a last index
   always_comb begin
      if (servers_in_use == '0) begin
         last_in = '0;
      end else if (32'(servers_in_use) > 32'(SERVERS)) begin
         last_in = IW'(SERVERS - 1);
      end else begin
         last_in = IW'(servers_in_use - 1'b1);
      end
   end

   // an entry not written since the last clear holds the open time of that clear
   assign cur_val    = rd_valid_ff ? rd_data_ff : FREE_W'(clear_open_ff);
   assign arr_ext    = FREE_W'(cur_ff.arrival);
   assign fin_wide   = {1'b0, start_ff} + (FREE_W + 1)'(cur_ff.svc);
   assign fin_sat    = fin_wide[FREE_W] ? '1 : fin_wide[FREE_W-1:0];
   assign total_wide = {1'b0, total_ff} + (TOTAL_W + 1)'(wait_ff);
   assign mem_wr     = state_ff == S_UPD;
   assign q_pop      = (state_ff == S_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         free_mem[best_ff] <= fin_sat;
      end
      rd_data_ff <= free_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issue_ff      <= 1'b0;
         pend_ff       <= 1'b0;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         clear_open_ff <= OPEN_RESET;
         total_ff      <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_idx_ff];
         // drop the response once taken, unless a new one replaces it
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cur_ff      <= q_item;
                  res_acc_ff  <= 1'b0;
                  res_idx_ff  <= '0;
                  res_wait_ff <= '0;
                  unique case (q_item.op)
                     OP_CLEAR: begin
                        valid_ff      <= '0;
                        clear_open_ff <= open_time;
                        total_ff      <= '0;
                        count_ff      <= '0;
                        state_ff      <= S_DONE;
                     end
                     OP_DROP: begin
                        state_ff <= S_DONE;
                     end
                     OP_JOB: begin
                        rd_idx_ff <= '0;
                        last_ff   <= last_in;
                        issue_ff  <= 1'b1;
                        pend_ff   <= 1'b0;
                        state_ff  <= S_SCAN;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               // issue one read a cycle, compare the word that came back
               if (issue_ff) begin
                  pend_ff      <= 1'b1;
                  pend_idx_ff  <= rd_idx_ff;
                  pend_last_ff <= rd_idx_ff == last_ff;
                  if (rd_idx_ff == last_ff) begin
                     issue_ff <= 1'b0;
                  end else begin
                     rd_idx_ff <= rd_idx_ff + 1'b1;
                  end
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff) begin
                  if (pend_idx_ff == '0 || cur_val < best_val_ff) begin
                     best_ff     <= pend_idx_ff;
                     best_val_ff <= cur_val;
                  end
                  if (pend_last_ff) begin
                     state_ff <= S_CALC;
                  end
               end
            end
            S_CALC: begin
               if (best_val_ff <= arr_ext) begin
                  wait_ff  <= '0;
                  start_ff <= arr_ext;
               end else begin
                  wait_ff  <= best_val_ff - arr_ext;
                  start_ff <= best_val_ff;
               end
               state_ff <= S_UPD;
            end
            S_UPD: begin
               valid_ff[best_ff] <= 1'b1;
               total_ff <= total_wide[TOTAL_W] ? '1 : total_wide[TOTAL_W-1:0];
               if (count_ff != '1) begin
                  count_ff <= count_ff + 1'b1;
               end
               res_acc_ff  <= 1'b1;
               res_idx_ff  <= best_ff;
               res_wait_ff <= wait_ff;
               state_ff    <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_accepted_ff <= res_acc_ff;
                  rsp_index_ff    <= IDX_OUT_W'(res_idx_ff);
                  rsp_wait_ff     <= res_wait_ff;
                  rsp_total_ff    <= total_ff;
                  rsp_count_ff    <= count_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_accepted           = rsp_accepted_ff;
   assign rsp_server_index       = rsp_index_ff;
   assign rsp_wait_seconds       = rsp_wait_ff;
   assign rsp_total_wait_seconds = rsp_total_ff;
   assign rsp_served_count       = rsp_count_ff;

endmodule
